FILE: rtl/core/dwsl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwsl_pkg: shared types and helpers for the wheel speed limiter
// Field widths, register indexes, reset values and the clamp and ramp
// functions used by the datapath.
// ----------------------------------------------------------------------------
package dwsl_pkg;

	localparam int SPEED_W    = 16;   // signed Q8.8 speeds and rates
	localparam int LIMIT_W    = 15;   // unsigned limit registers
	localparam int HALF_W     = 16;   // Q1.15 half track
	localparam int DT_W       = 16;   // Q0.16 time step
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TURN_FRAC  = 15;   // Q8.8 * Q1.15 -> Q8.8
	localparam int STEP_FRAC  = 16;   // Q8.8 * Q0.16 -> Q8.8
	localparam int WIDE_W     = SPEED_W + 3;               // targets before clamp
	localparam int PROD_W     = SPEED_W + HALF_W + 1;      // turn product
	localparam int SPROD_W    = LIMIT_W + DT_W;            // step product
	localparam int GAP_W      = SPEED_W + 1;

	localparam logic [LIMIT_W-1:0] RST_MAX_LINEAR = LIMIT_W'(512);
	localparam logic [LIMIT_W-1:0] RST_MAX_TURN   = LIMIT_W'(768);
	localparam logic [HALF_W-1:0]  RST_SEMI_TRACK = HALF_W'(6554);
	localparam logic [LIMIT_W-1:0] RST_MAX_WHEEL  = LIMIT_W'(512);
	localparam logic [LIMIT_W-1:0] RST_MAX_ACCEL  = LIMIT_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MAX_LINEAR = 3'd0,
		CFG_MAX_TURN   = 3'd1,
		CFG_SEMI_TRACK = 3'd2,
		CFG_MAX_WHEEL  = 3'd3,
		CFG_MAX_ACCEL  = 3'd4
	} cfg_reg_t;

	typedef logic signed [SPEED_W-1:0] speed_t;
	typedef logic [LIMIT_W-1:0] limit_t;

	typedef struct packed {
		speed_t val;
		logic   hit;
	} speed_flag_t;

	// Symmetric clamp to +-lim; hit when the value lies strictly outside
	function automatic speed_flag_t clamp_sym(input logic signed [WIDE_W-1:0] x,
		input limit_t lim);
		logic signed [WIDE_W-1:0] pos;
		logic signed [WIDE_W-1:0] neg;
		speed_flag_t r;
		pos = signed'({{(WIDE_W-LIMIT_W){1'b0}}, lim});
		neg = -pos;
		r.hit = 1'b1;
		if (x > pos) begin
			r.val = pos[SPEED_W-1:0];
		end else if (x < neg) begin
			r.val = neg[SPEED_W-1:0];
		end else begin
			r.val = x[SPEED_W-1:0];
			r.hit = 1'b0;
		end
		return r;
	endfunction

	// Move cur toward tgt by at most step; snap when within reach
	function automatic speed_flag_t ramp(input speed_t cur, input speed_t tgt,
		input limit_t step);
		logic signed [GAP_W-1:0] gap;
		logic signed [GAP_W-1:0] stp;
		logic signed [GAP_W-1:0] sum;
		speed_flag_t r;
		gap = GAP_W'(tgt) - GAP_W'(cur);
		stp = signed'({{(GAP_W-LIMIT_W){1'b0}}, step});
		r.hit = 1'b1;
		if (gap > stp) begin
			sum = GAP_W'(cur) + stp;
		end else if (gap < -stp) begin
			sum = GAP_W'(cur) - stp;
		end else begin
			sum = GAP_W'(tgt);
			r.hit = 1'b0;
		end
		r.val = sum[SPEED_W-1:0];
		return r;
	endfunction

endpackage

FILE: rtl/core/dwsl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwsl_if: command and wheel channels of the wheel speed limiter
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface dwsl_cmd_if;
	import dwsl_pkg::*;
	logic                valid;
	logic                ready;
	speed_t              linear_cmd;
	speed_t              turn_cmd;
	logic [DT_W-1:0]     time_step;

	modport source (output valid, linear_cmd, turn_cmd, time_step, input ready);
	modport sink   (input valid, linear_cmd, turn_cmd, time_step, output ready);
endinterface

interface dwsl_wheel_if;
	import dwsl_pkg::*;
	logic   valid;
	logic   ready;
	speed_t left_speed;
	speed_t right_speed;
	speed_t applied_linear;
	speed_t applied_turn;
	logic   wheel_saturated;
	logic   accel_limited;

	modport source (output valid, left_speed, right_speed, applied_linear, applied_turn,
		wheel_saturated, accel_limited, input ready);
	modport sink   (input valid, left_speed, right_speed, applied_linear, applied_turn,
		wheel_saturated, accel_limited, output ready);
endinterface

FILE: rtl/core/diff_drive_wheel_speed_limiter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diff_drive_wheel_speed_limiter_unit: differential drive speed limiter
// Clamps speed commands, forms wheel targets and slew limits each wheel.
// ----------------------------------------------------------------------------
// Usage:
//   cmd   : one item per control tick (linear_cmd, turn_cmd, time_step).
//   wheel : one item per command item (ramped wheel speeds, clamped
//           commands, saturation and acceleration flags), in order.
//   wr_*  : register write port; write only while no item is in flight.
// Pipeline: input register, clamp and multiply stage, target stage, then
//   ramp into the output register. One item per cycle is accepted
//   sustained while the output register is not held by a stall.
//   The wheel speed state is read and written in the last stage only, so
//   consecutive items chain through it with no gap.
// Stall: the whole pipeline holds while the output register is full and
//   not taken; cmd.ready is high whenever the output register is empty or
//   being taken in this cycle.
// Reset: arst_n clears valid bits and wheel speeds to zero and loads the
//   register reset values.
// ----------------------------------------------------------------------------
module diff_drive_wheel_speed_limiter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	dwsl_cmd_if.sink                          cmd,
	dwsl_wheel_if.source                      wheel,
	input  logic                              wr_en,
	input  logic [dwsl_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [dwsl_pkg::CFG_DATA_W-1:0]   wr_data
);
	import dwsl_pkg::*;

	// configuration
	limit_t            max_linear_q;
	limit_t            max_turn_q;
	logic [HALF_W-1:0] semi_track_q;
	limit_t            max_wheel_q;
	limit_t            max_accel_q;

	// pipeline
	logic                     adv;
	logic                     s1_valid, s2_valid, s3_valid, out_valid_q;
	speed_t                   lin_s1, turn_s1;
	logic [DT_W-1:0]          dt_s1;
	speed_t                   v_s2, w_s2;
	logic signed [PROD_W-1:0] prod_s2;
	limit_t                   step_s2;
	speed_t                   v_s3, w_s3, tl_s3, tr_s3;
	logic                     sat_s3;
	limit_t                   step_s3;

	// wheel state and output register
	speed_t left_q, right_q;
	speed_t left_out_q, right_out_q, lin_out_q, turn_out_q;
	logic   sat_out_q, lim_out_q;

	// stage 2 combinational
	speed_flag_t              v_c, w_c;
	logic signed [PROD_W-1:0] prod_c;
	logic [SPROD_W-1:0]       sprod_c;

	// stage 3 combinational
	logic signed [WIDE_W-1:0] turn_c, tl_w, tr_w;
	speed_flag_t              tl_c, tr_c;

	// ramp
	speed_flag_t              left_c, right_c;

	assign adv       = !out_valid_q || wheel.ready;
	assign cmd.ready = adv;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_linear_q <= RST_MAX_LINEAR;
			max_turn_q   <= RST_MAX_TURN;
			semi_track_q <= RST_SEMI_TRACK;
			max_wheel_q  <= RST_MAX_WHEEL;
			max_accel_q  <= RST_MAX_ACCEL;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_MAX_LINEAR: max_linear_q <= wr_data[LIMIT_W-1:0];
				CFG_MAX_TURN:   max_turn_q   <= wr_data[LIMIT_W-1:0];
				CFG_SEMI_TRACK: semi_track_q <= wr_data[HALF_W-1:0];
				CFG_MAX_WHEEL:  max_wheel_q  <= wr_data[LIMIT_W-1:0];
				CFG_MAX_ACCEL:  max_accel_q  <= wr_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Valid bits move together with the stall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			s2_valid    <= 1'b0;
			s3_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			s1_valid    <= cmd.valid;
			s2_valid    <= s1_valid;
			s3_valid    <= s2_valid;
			out_valid_q <= s3_valid;
		end
	end

	// Clamp commands, turn product, slew step
	always_comb begin
		v_c     = clamp_sym(WIDE_W'(lin_s1), max_linear_q);
		w_c     = clamp_sym(WIDE_W'(turn_s1), max_turn_q);
		prod_c  = PROD_W'(w_c.val) * $signed({1'b0, semi_track_q});
		sprod_c = SPROD_W'(max_accel_q) * SPROD_W'(dt_s1);
	end

	// Wheel targets: v -+ floor(w*h / 2^15), clamped to the wheel limit
	always_comb begin
		turn_c = WIDE_W'(prod_s2 >>> TURN_FRAC);
		tl_w   = WIDE_W'(v_s2) - turn_c;
		tr_w   = WIDE_W'(v_s2) + turn_c;
		tl_c   = clamp_sym(tl_w, max_wheel_q);
		tr_c   = clamp_sym(tr_w, max_wheel_q);
	end

	// Slew each wheel toward its target
	always_comb begin
		left_c  = ramp(left_q, tl_s3, step_s3);
		right_c = ramp(right_q, tr_s3, step_s3);
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (adv) begin
			lin_s1      <= cmd.linear_cmd;
			turn_s1     <= cmd.turn_cmd;
			dt_s1       <= cmd.time_step;
			v_s2        <= v_c.val;
			w_s2        <= w_c.val;
			prod_s2     <= prod_c;
			step_s2     <= sprod_c[SPROD_W-1:STEP_FRAC];
			v_s3        <= v_s2;
			w_s3        <= w_s2;
			tl_s3       <= tl_c.val;
			tr_s3       <= tr_c.val;
			sat_s3      <= tl_c.hit | tr_c.hit;
			step_s3     <= step_s2;
			left_out_q  <= left_c.val;
			right_out_q <= right_c.val;
			lin_out_q   <= v_s3;
			turn_out_q  <= w_s3;
			sat_out_q   <= sat_s3;
			lim_out_q   <= left_c.hit | right_c.hit;
		end
	end

	// Wheel speed state advances once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q  <= '0;
			right_q <= '0;
		end else if (adv && s3_valid) begin
			left_q  <= left_c.val;
			right_q <= right_c.val;
		end
	end

	assign wheel.valid           = out_valid_q;
	assign wheel.left_speed      = left_out_q;
	assign wheel.right_speed     = right_out_q;
	assign wheel.applied_linear  = lin_out_q;
	assign wheel.applied_turn    = turn_out_q;
	assign wheel.wheel_saturated = sat_out_q;
	assign wheel.accel_limited   = lim_out_q;

	// The presented result matches the stored wheel state
	a_state_matches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && s3_valid) |=> (left_q == wheel.left_speed && right_q == wheel.right_speed))
		else $error("wheel state and output register disagree");

	// An accepted item reaches the first stage
	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> s1_valid)
		else $error("accepted item lost at input register");

	// The pipeline frees up whenever the output is empty
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!wheel.valid |-> cmd.ready)
		else $error("input stalled with empty output register");

	// Applied linear command stays inside its clamp
	a_linear_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		wheel.valid |-> ($signed({wheel.applied_linear[SPEED_W-1], wheel.applied_linear})
			<= $signed({2'b00, max_linear_q})
		&& $signed({wheel.applied_linear[SPEED_W-1], wheel.applied_linear})
			>= -$signed({2'b00, max_linear_q})))
		else $error("applied linear command outside clamp");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the differential drive speed limiter
// Sends speed command items through the cmd channel. A shadow model of the
// limit registers and wheel state predicts each wheel item. A monitor on the
// wheel channel compares every field in order. Both channels throttle at
// random except in the last two phases. The limit registers are reloaded
// between phases, including zero and full-scale settings.
// ----------------------------------------------------------------------------
module tb_top;
	import dwsl_pkg::*;

	// unused register slots; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_MID = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI  = 3'd7;
	localparam int SETTLE_CYCLES = 8;   // pipeline is four deep
	localparam int CLK_HALF      = 5;

	typedef struct packed {
		speed_t          linear;
		speed_t          turn;
		logic [DT_W-1:0] dt;
	} tick_t;

	typedef struct packed {
		speed_t left;
		speed_t right;
		speed_t lin;
		speed_t turn;
		logic   sat;
		logic   lim;
	} wheel_out_t;

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	dwsl_cmd_if   cmd_ch ();
	dwsl_wheel_if wheel_ch ();

	diff_drive_wheel_speed_limiter_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_ch),
		.wheel    (wheel_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// shadow registers and wheel state
	limit_t          lin_limit;
	limit_t          turn_limit;
	logic [HALF_W-1:0] semi_track;
	limit_t          wheel_limit;
	limit_t          accel_limit;
	speed_t          left_state;
	speed_t          right_state;

	tick_t      ticks_pending[$];
	wheel_out_t expected_wheels[$];
	logic       cmd_taken;
	int         send_idle_pct;
	int         recv_idle_pct;
	int         mismatches;

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// hard stop
	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic longint bound(longint x, longint lim);
		if (x > lim) begin
			return lim;
		end else if (x < -lim) begin
			return -lim;
		end
		return x;
	endfunction

	// move one wheel toward its target by at most step
	function automatic speed_flag_t slew(speed_t cur, longint tgt, longint step);
		longint gap;
		speed_flag_t r;
		gap = tgt - longint'(cur);
		r.hit = (gap > step) || (gap < -step);
		if (gap > step) begin
			r.val = speed_t'(longint'(cur) + step);
		end else if (gap < -step) begin
			r.val = speed_t'(longint'(cur) - step);
		end else begin
			r.val = speed_t'(tgt);
		end
		return r;
	endfunction

	// predicted wheel item for one command item; advances the wheel state
	function automatic wheel_out_t next_wheels(tick_t t);
		longint v, w, turn, tl, tr, wl, step;
		speed_flag_t l, r;
		wheel_out_t o;
		v    = bound(longint'(t.linear), longint'(lin_limit));
		w    = bound(longint'(t.turn), longint'(turn_limit));
		turn = (w * longint'(semi_track)) >>> TURN_FRAC;   // floor
		tl   = v - turn;
		tr   = v + turn;
		wl   = longint'(wheel_limit);
		o.sat = (tl > wl) || (tl < -wl) || (tr > wl) || (tr < -wl);
		step = (longint'(accel_limit) * longint'(t.dt)) >>> STEP_FRAC;
		l = slew(left_state, bound(tl, wl), step);
		r = slew(right_state, bound(tr, wl), step);
		left_state  = l.val;
		right_state = r.val;
		o.left  = l.val;
		o.right = r.val;
		o.lin   = speed_t'(v);
		o.turn  = speed_t'(w);
		o.lim   = l.hit || r.hit;
		return o;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
		input logic [15:0] seen);
		if (seen !== want) begin
			$display("%0t: %s expected %0d got %0d", $time, name,
				$signed(want), $signed(seen));
			mismatches++;
		end
	endtask

	// command driver
	always @(negedge clk) begin : cmd_drive
		tick_t t;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
		end else if (cmd_ch.valid && !cmd_taken) begin
			// item still waiting for ready
		end else if (ticks_pending.size() != 0 &&
				$urandom_range(99, 0) >= send_idle_pct) begin
			t = ticks_pending.pop_front();
			cmd_ch.valid      <= 1'b1;
			cmd_ch.linear_cmd <= t.linear;
			cmd_ch.turn_cmd   <= t.turn;
			cmd_ch.time_step  <= t.dt;
		end else begin
			cmd_ch.valid <= 1'b0;
		end
	end

	// wheel channel back-pressure
	always @(negedge clk) begin
		wheel_ch.ready <= arst_n && ($urandom_range(99, 0) >= recv_idle_pct);
	end

	// accept tracking, prediction and checking
	always @(posedge clk) begin : wheel_mon
		tick_t t;
		wheel_out_t want;
		cmd_taken <= cmd_ch.valid && cmd_ch.ready;
		if (arst_n && wheel_ch.valid && wheel_ch.ready) begin
			if (expected_wheels.size() == 0) begin
				$display("%0t: wheel item with none expected, left %0d right %0d",
					$time, wheel_ch.left_speed, wheel_ch.right_speed);
				mismatches++;
			end else begin
				want = expected_wheels.pop_front();
				check_field("left_speed", want.left, wheel_ch.left_speed);
				check_field("right_speed", want.right, wheel_ch.right_speed);
				check_field("applied_linear", want.lin, wheel_ch.applied_linear);
				check_field("applied_turn", want.turn, wheel_ch.applied_turn);
				check_field("wheel_saturated", 16'(want.sat), 16'(wheel_ch.wheel_saturated));
				check_field("accel_limited", 16'(want.lim), 16'(wheel_ch.accel_limited));
			end
		end
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			t.linear = cmd_ch.linear_cmd;
			t.turn   = cmd_ch.turn_cmd;
			t.dt     = cmd_ch.time_step;
			expected_wheels.push_back(next_wheels(t));
		end
	end

	// register write; shadow follows with the register width mask
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		case (idx)
			CFG_MAX_LINEAR: lin_limit   = data[LIMIT_W-1:0];
			CFG_MAX_TURN:   turn_limit  = data[LIMIT_W-1:0];
			CFG_SEMI_TRACK: semi_track  = data[HALF_W-1:0];
			CFG_MAX_WHEEL:  wheel_limit = data[LIMIT_W-1:0];
			CFG_MAX_ACCEL:  accel_limit = data[LIMIT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic load_limits(input int lin, input int turn, input int half,
		input int wheel, input int accel);
		set_reg(CFG_MAX_LINEAR, CFG_DATA_W'(lin));
		set_reg(CFG_MAX_TURN, CFG_DATA_W'(turn));
		set_reg(CFG_SEMI_TRACK, CFG_DATA_W'(half));
		set_reg(CFG_MAX_WHEEL, CFG_DATA_W'(wheel));
		set_reg(CFG_MAX_ACCEL, CFG_DATA_W'(accel));
		@(negedge clk);
	endtask

	// hold off until every item has come back and the pipe is empty;
	// checked at the rising edge, where driver updates have settled
	task automatic wait_idle();
		while (ticks_pending.size() != 0 || cmd_ch.valid || expected_wheels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic send_tick(input int lin, input int turn, input int dt);
		tick_t t;
		t.linear = speed_t'(lin);
		t.turn   = speed_t'(turn);
		t.dt     = DT_W'(dt);
		ticks_pending.push_back(t);
	endtask

	// speeds: full range, around the clamp, on the clamp, near zero
	function automatic speed_t pick_speed(int lim);
		int v;
		case ($urandom_range(3, 0))
			0: v = int'($urandom);
			1: v = int'($urandom_range(2 * lim + 64, 0)) - lim - 32;
			2: v = $urandom_range(1, 0) ? lim : -lim;
			default: v = int'($urandom_range(64, 0)) - 32;
		endcase
		return speed_t'(v);
	endfunction

	function automatic logic [DT_W-1:0] pick_dt();
		case ($urandom_range(3, 0))
			0: return DT_W'($urandom);
			1: return DT_W'($urandom_range(4095, 0));
			2: return $urandom_range(1, 0) ? {DT_W{1'b1}} : {DT_W{1'b0}};
			default: return DT_W'($urandom_range(1023, 0));
		endcase
	endfunction

	task automatic send_random(input int n);
		tick_t t;
		repeat (n) begin
			t.linear = pick_speed(int'(lin_limit));
			t.turn   = pick_speed(int'(turn_limit));
			t.dt     = pick_dt();
			ticks_pending.push_back(t);
		end
	endtask

	// sequence of phases
	initial begin
		arst_n            = 1'b0;
		wr_en             = 1'b0;
		wr_index          = '0;
		wr_data           = '0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.linear_cmd = '0;
		cmd_ch.turn_cmd   = '0;
		cmd_ch.time_step  = '0;
		wheel_ch.ready    = 1'b0;
		cmd_taken         = 1'b0;
		mismatches        = 0;
		send_idle_pct     = 37;
		recv_idle_pct     = 50;
		lin_limit         = RST_MAX_LINEAR;
		turn_limit        = RST_MAX_TURN;
		semi_track        = RST_SEMI_TRACK;
		wheel_limit       = RST_MAX_WHEEL;
		accel_limit       = RST_MAX_ACCEL;
		left_state        = '0;
		right_state       = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed items on reset limits
		send_tick(0, 0, 0);             // on target with no time step
		send_tick(32767, 0, 65535);     // linear clamp, slew limited
		send_tick(512, 0, 65535);       // target exactly on wheel limit
		send_tick(512, 0, 0);           // no time step, off target: holds
		send_tick(-32768, -32768, 65535);
		send_tick(0, 32767, 65535);     // turn clamp
		send_tick(0, -32768, 65535);
		send_tick(512, 768, 65535);     // one wheel over its limit
		send_tick(-512, 768, 0);
		send_tick(100, -200, 1);        // step truncates to zero
		repeat (4) send_tick(0, 0, 65535);
		send_tick(-1, -1, 32768);
		send_tick(-513, -769, 65535);
		wait_idle();

		// moderate random limits
		load_limits($urandom_range(2048, 1), $urandom_range(2048, 1),
			$urandom_range(65535, 0), $urandom_range(1024, 1), $urandom_range(4096, 1));
		send_random(150);
		wait_idle();

		// full-scale limits
		send_idle_pct = 50;
		recv_idle_pct = 37;
		load_limits(32767, 32767, 65535, 32767, 32767);
		send_tick(32767, 32767, 65535);
		send_tick(-32768, -32768, 65535);
		send_tick(32767, -32768, 65535);
		send_tick(-32768, 32767, 65535);
		send_random(100);
		wait_idle();

		// zero limits clamp commands and targets to zero; the wheels hold still
		load_limits(0, 0, 0, 0, 0);
		send_tick(32767, 32767, 65535);
		send_tick(-32768, -32768, 65535);
		send_random(30);
		wait_idle();

		// bits above the register width are dropped; spare slots ignored
		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_limits(16'h8300, 16'hC400, 16'h1999, 16'h8280, 16'hFFFF & 16'h8100);
		set_reg(CFG_SPARE_LO, 16'h0000);
		set_reg(CFG_SPARE_MID, 16'hFFFF);
		set_reg(CFG_SPARE_HI, 16'h0000);
		@(negedge clk);
		send_random(120);
		wait_idle();

		// fully random register contents
		load_limits($urandom, $urandom, $urandom, $urandom, $urandom);
		send_random(100);
		wait_idle();

		if (mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
